// ===== rtl/cel_pkg.sv =====
// ----------------------------------------------------------------------------
// cel_pkg: shared types and constants for the cosine embedding loss block
// Holds the controller/datapath command and status structs and fixed widths.
// ----------------------------------------------------------------------------
package cel_pkg;

    localparam int ElemW    = 16;
    localparam int AccW     = 48;
    localparam int WideW    = 128;
    localparam int ProdW    = 96;
    localparam int QW       = 15;
    localparam int TW       = 30;
    localparam int MulSteps = 48;
    localparam int CntW     = 6;
    localparam int NumShift = 30;

    localparam logic [QW-1:0] OneQ14 = 15'd16384;

    // configuration register indexes
    localparam logic CfgLossMode = 1'b0;
    localparam logic CfgMargin   = 1'b1;

    typedef struct packed {
        logic acc_en;
        logic mul_ld_norm;
        logic mul_ld_mag;
        logic mul_ld_srch;
        logic mul_step;
        logic save_prod;
        logic srch_init;
        logic calc_t;
        logic decide;
        logic finish;
    } cel_cmd_t;

    typedef struct packed {
        logic zero_norm;
        logic mul_last;
        logic srch_done;
        logic out_busy;
    } cel_status_t;

endpackage

// ===== rtl/cosine_embedding_loss.sv =====
// ----------------------------------------------------------------------------
// cosine_embedding_loss: streamed cosine distance / embedding loss
// Sums a*b, a*a, b*b per vector pair and emits one Q2.14 loss per pair.
// ----------------------------------------------------------------------------
//  channel  dir  tdata (low bit up)       tuser          tlast
//  s_       in   elem_a, elem_b           pair_similar   last_elem
//  m_       out  loss                     zero_norm      -
//  cfg_     in   index 0 loss_mode, index 1 margin (write only)
//
//  A non-last element is summed as it is taken. The last element starts the
//  cosine: one shift-add multiplier forms |a|^2*|b|^2 and dot^2, then a
//  14- or 15-step binary search does one product each, while s_tready
//  stays low. A zero norm skips the multiplier and the search.
//  Reset is synchronous, active low; a waiting result holds in the output
//  register and stalls only the next pair's final step.
// ----------------------------------------------------------------------------
module cosine_embedding_loss (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // elem_a [15:0], elem_b [31:16]
    input  logic        s_tuser,   // pair_similar
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // loss [15:0]
    output logic        m_tuser,   // zero_norm
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wdata
);
    import cel_pkg::*;

    cel_cmd_t    cmd;
    cel_status_t status;
    logic        mode_reg;
    logic [15:0] margin_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= 1'b1;
            margin_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CfgLossMode: mode_reg   <= cfg_wdata[0];
                CfgMargin:   margin_reg <= cfg_wdata;
                default:     mode_reg   <= mode_reg;
            endcase
        end
    end

    cel_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_last  (s_tlast),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    cel_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .elem_a       (s_tdata[15:0]),
        .elem_b       (s_tdata[31:16]),
        .pair_similar (s_tuser),
        .last_elem    (s_tlast),
        .loss_mode    (mode_reg),
        .margin       (margin_reg),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .loss         (m_tdata),
        .zero_norm    (m_tuser)
    );

endmodule

// ===== rtl/cel_ctrl.sv =====
// ----------------------------------------------------------------------------
// cel_ctrl: sequencer for the cosine embedding loss block
// Accepts elements, then steps the shared multiplier and the cosine search.
// ----------------------------------------------------------------------------
module cel_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  logic                 in_last,
    output logic                 in_ready,
    input  cel_pkg::cel_status_t status,
    output cel_pkg::cel_cmd_t    cmd
);
    import cel_pkg::*;

    typedef enum logic [8:0] {
        S_ACC   = 9'b000000001,
        S_CHK   = 9'b000000010,
        S_MNORM = 9'b000000100,
        S_PROD  = 9'b000001000,
        S_MMAG  = 9'b000010000,
        S_TCALC = 9'b000100000,
        S_LDS   = 9'b001000000,
        S_MSRCH = 9'b010000000,
        S_DEC   = 9'b100000000
    } state_t;

    // fin_reg marks a result that loads once the output register frees
    state_t state_reg, state_next;
    logic   fin_reg, fin_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_ACC;
            fin_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        fin_next   = fin_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        if (fin_reg) begin
            // wait for the output register, then load it and clear the sums
            if (!status.out_busy) begin
                cmd.finish = 1'b1;
                fin_next   = 1'b0;
                state_next = S_ACC;
            end
        end else begin
            unique case (state_reg)
                S_ACC: begin
                    in_ready   = 1'b1;
                    cmd.acc_en = in_valid;
                    if (in_valid && in_last) begin
                        state_next = S_CHK;
                    end
                end
                S_CHK: begin
                    if (status.zero_norm) begin
                        fin_next = 1'b1;
                    end else begin
                        cmd.mul_ld_norm = 1'b1;
                        state_next      = S_MNORM;
                    end
                end
                S_MNORM: begin
                    cmd.mul_step = 1'b1;
                    if (status.mul_last) begin
                        state_next = S_PROD;
                    end
                end
                S_PROD: begin
                    cmd.save_prod  = 1'b1;
                    cmd.mul_ld_mag = 1'b1;
                    state_next     = S_MMAG;
                end
                S_MMAG: begin
                    cmd.mul_step = 1'b1;
                    if (status.mul_last) begin
                        cmd.srch_init = 1'b1;
                        state_next    = S_TCALC;
                    end
                end
                S_TCALC: begin
                    if (status.srch_done) begin
                        fin_next = 1'b1;
                    end else begin
                        cmd.calc_t = 1'b1;
                        state_next = S_LDS;
                    end
                end
                S_LDS: begin
                    cmd.mul_ld_srch = 1'b1;
                    state_next      = S_MSRCH;
                end
                S_MSRCH: begin
                    cmd.mul_step = 1'b1;
                    if (status.mul_last) begin
                        state_next = S_DEC;
                    end
                end
                S_DEC: begin
                    cmd.decide = 1'b1;
                    state_next = S_TCALC;
                end
                default: begin
                    state_next = S_ACC;
                end
            endcase
        end
    end

endmodule

// ===== rtl/cel_dp.sv =====
// ----------------------------------------------------------------------------
// cel_dp: datapath of the cosine embedding loss block
// Sums, shared shift-add multiplier, cosine search and result register.
// ----------------------------------------------------------------------------
module cel_dp (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  cel_pkg::cel_cmd_t           cmd,
    output cel_pkg::cel_status_t        status,
    input  logic [cel_pkg::ElemW-1:0]   elem_a,
    input  logic [cel_pkg::ElemW-1:0]   elem_b,
    input  logic                        pair_similar,
    input  logic                        last_elem,
    input  logic                        loss_mode,
    input  logic [cel_pkg::ElemW-1:0]   margin,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [cel_pkg::ElemW-1:0]   loss,
    output logic                        zero_norm
);
    import cel_pkg::*;

    logic [AccW-1:0]  dot_reg, na_reg, nb_reg;
    logic             sim_reg;
    logic [WideW-1:0] mx_reg, mp_reg;
    logic [AccW-1:0]  my_reg;
    logic [CntW-1:0]  cnt_reg;
    logic [ProdW-1:0] prod_reg;
    logic [WideW-1:0] num_reg;
    logic [QW-1:0]    lo_reg, hi_reg, q_reg;
    logic [TW-1:0]    t_reg;
    logic             ov_reg;
    logic [ElemW-1:0] loss_reg;
    logic             zn_reg;

    logic signed [31:0] p_ab, p_aa, p_bb;
    logic [AccW-1:0]    mag;
    logic               zn;
    logic [QW:0]        qsum;
    logic [QW-1:0]      q;
    logic [QW:0]        tm;
    logic [2*QW+1:0]    tsq;
    logic [WideW-1:0]   mp_next;
    logic signed [18:0] cosv, lraw, lcl;
    logic [ElemW-1:0]   loss_next;

    // element products
    assign p_ab = $signed(elem_a) * $signed(elem_b);
    assign p_aa = $signed(elem_a) * $signed(elem_a);
    assign p_bb = $signed(elem_b) * $signed(elem_b);

    assign mag = dot_reg[AccW-1] ? (~dot_reg + 1'b1) : dot_reg;
    assign zn  = (na_reg == '0) || (nb_reg == '0);

    // accumulate, clear when the result is loaded into the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_reg <= '0;
            na_reg  <= '0;
            nb_reg  <= '0;
        end else if (cmd.finish) begin
            dot_reg <= '0;
            na_reg  <= '0;
            nb_reg  <= '0;
        end else if (cmd.acc_en) begin
            dot_reg <= dot_reg + {{(AccW-32){p_ab[31]}}, p_ab};
            na_reg  <= na_reg + {{(AccW-32){1'b0}}, p_aa};
            nb_reg  <= nb_reg + {{(AccW-32){1'b0}}, p_bb};
        end
    end

    // hold the label of the last element
    always_ff @(posedge aclk) begin
        if (cmd.acc_en && last_elem) begin
            sim_reg <= pair_similar;
        end
    end

    // shift-add multiplier, one multiplier bit a cycle
    assign mp_next = my_reg[0] ? (mp_reg + mx_reg) : mp_reg;

    always_ff @(posedge aclk) begin
        priority if (cmd.mul_ld_norm) begin
            mx_reg  <= {{(WideW-AccW){1'b0}}, na_reg};
            my_reg  <= nb_reg;
            mp_reg  <= '0;
            cnt_reg <= '0;
        end else if (cmd.mul_ld_mag) begin
            mx_reg  <= {{(WideW-AccW){1'b0}}, mag};
            my_reg  <= mag;
            mp_reg  <= '0;
            cnt_reg <= '0;
        end else if (cmd.mul_ld_srch) begin
            mx_reg  <= {{(WideW-ProdW){1'b0}}, prod_reg};
            my_reg  <= {{(AccW-TW){1'b0}}, t_reg};
            mp_reg  <= '0;
            cnt_reg <= '0;
        end else if (cmd.mul_step) begin
            mp_reg  <= mp_next;
            mx_reg  <= {mx_reg[WideW-2:0], 1'b0};
            my_reg  <= {1'b0, my_reg[AccW-1:1]};
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // the final step's sum of dot^2 goes straight into num_reg; prod_reg takes the finished norm product
    always_ff @(posedge aclk) begin
        if (cmd.save_prod) begin
            prod_reg <= mp_reg[ProdW-1:0];
        end
        if (cmd.srch_init) begin
            num_reg <= {mp_next[WideW-NumShift-1:0], {NumShift{1'b0}}};
        end
    end

    // binary search of the rounded cosine magnitude
    assign qsum = {1'b0, lo_reg} + {1'b0, hi_reg} + 1'b1;
    assign q    = qsum[QW:1];
    assign tm   = {q, 1'b0} - 1'b1;
    assign tsq  = tm * tm;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lo_reg <= '0;
            hi_reg <= '0;
        end else if (cmd.srch_init) begin
            lo_reg <= '0;
            hi_reg <= OneQ14;
        end else if (cmd.decide) begin
            if (mp_reg <= num_reg) begin
                lo_reg <= q_reg;
            end else begin
                hi_reg <= q_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.calc_t) begin
            q_reg <= q;
            t_reg <= tsq[TW-1:0];
        end
    end

    // loss from the signed cosine
    always_comb begin
        cosv = dot_reg[AccW-1] ? -$signed({4'b0, lo_reg}) : $signed({4'b0, lo_reg});
        if (!loss_mode || sim_reg) begin
            lraw = $signed({4'b0, OneQ14}) - cosv;
            lcl  = lraw;
        end else begin
            lraw = cosv - 19'(signed'(margin));
            lcl  = lraw[18] ? 19'sd0 : lraw;
        end
        if (lcl > 19'sd32767) begin
            loss_next = 16'h7fff;
        end else begin
            loss_next = lcl[ElemW-1:0];
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (cmd.finish) begin
            ov_reg <= 1'b1;
        end else if (out_ready) begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            loss_reg <= zn ? '0 : loss_next;
            zn_reg   <= zn;
        end
    end

    assign status.zero_norm = zn;
    assign status.mul_last  = (cnt_reg == CntW'(MulSteps-1));
    assign status.srch_done = (lo_reg == hi_reg);
    assign status.out_busy  = ov_reg && !out_ready;

    assign out_valid = ov_reg;
    assign loss      = loss_reg;
    assign zero_norm = zn_reg;

`ifndef SYNTHESIS
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> (dot_reg == '0) && (na_reg == '0) && (nb_reg == '0))
        else $error("sums not cleared after a result");
    a_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (lo_reg <= hi_reg) && (hi_reg <= OneQ14))
        else $error("search bounds crossed");
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (ov_reg && zn_reg) |-> (loss_reg == '0))
        else $error("zero-norm result with nonzero loss");
`endif

endmodule
